[sv/temperature_gradient_tracker_macros.svh]
// ----------------------------------------------------------------------------
// temperature_gradient_tracker_macros.svh
// Assertion shorthands for the temperature gradient tracker.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_GRADIENT_TRACKER_MACROS_SVH
`define TEMPERATURE_GRADIENT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tgt_pkg.sv]
// ----------------------------------------------------------------------------
// tgt_pkg
// Widths, register map and conversion constants of the gradient tracker.
// ----------------------------------------------------------------------------
package tgt_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int WORD_W       = 19;
    localparam int WIN_W        = 7;
    localparam int DIV_CNT_W    = $clog2(WORD_W + 1);
    localparam int DEF_MAX_WIN  = 64;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 40;

    // Register index, taken from paddr[2]
    localparam logic REG_WINDOW_LEN = 1'b0;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 7'd8;

    // temp_q8 = 225 * sample - 14848 (1/256 degree F)
    localparam logic [WORD_W-1:0] TEMP_SCALE  = 19'd225;
    localparam logic [WORD_W-1:0] TEMP_OFFSET = 19'd14848;

    function automatic logic [WORD_W-1:0] temp_from_sample(input logic [SAMPLE_W-1:0] s);
        logic [WORD_W-1:0] prod;
        prod = WORD_W'(s) * TEMP_SCALE;
        return prod - TEMP_OFFSET;
    endfunction

endpackage

[sv/temperature_gradient_tracker.sv]
// ----------------------------------------------------------------------------
// temperature_gradient_tracker
// Moving average of first temperature differences from a 10-bit sensor.
// ----------------------------------------------------------------------------
// Input stream s_*: one ADC sample per transaction (s_tdata[9:0]).
// Output stream m_*: one result per input sample. m_tdata[18:0] carries the
// temperature in 1/256 degree F, m_tdata[37:19] the mean difference over the
// window; m_tuser is set once the window is full (gradient is zero otherwise).
// APB register 0 (address 0) holds window_len; writing it empties the window
// but keeps the last temperature. 0 acts as 1, values above MAX_WINDOW clip.
// Each sample runs accept, convert and ring update; a sample that yields a
// valid gradient then runs a restoring divider by the window length that
// retires one quotient bit per cycle; any other sample skips the divider.
// The 19-bit serial divider sets the rate. The next sample is taken as soon
// as the result sits in the output register, and not before.
// If the receiver stalls, the finished result waits in the output register and
// the next sample stops before loading its own result.
// Reset (aresetn low, synchronous) empties the window, forgets the previous
// temperature and sets window_len to 8. The ring memory needs no clearing.
// ----------------------------------------------------------------------------
`include "temperature_gradient_tracker_macros.svh"

module temperature_gradient_tracker #(
    parameter int MAX_WINDOW = tgt_pkg::DEF_MAX_WIN
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: [9:0] adc_sample, [15:10] zero
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tgt_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [18:0] temperature_q8, [37:19] gradient_q8, [39:38] zero
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tgt_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: [0] gradient_valid
    output logic                         m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tgt_pkg::ADDR_W-1:0]   paddr,
    input  logic [tgt_pkg::DATA_W-1:0]   pwdata,
    output logic [tgt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int WW = tgt_pkg::WORD_W;
    localparam int NW = tgt_pkg::WIN_W;
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int CW = ((PW > NW) ? PW : NW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                            state_reg;
    logic                              m_tvalid_reg;
    logic [tgt_pkg::M_TDATA_W-1:0]     m_tdata_reg;
    logic                              m_tuser_reg;
    logic [NW-1:0]                     window_len_reg;
    logic [tgt_pkg::SAMPLE_W-1:0]      sample_reg;
    logic [WW-1:0]                     prev_temp_reg;
    logic                              have_prev_reg;
    logic                              use_ring_reg;
    logic [WW-1:0]                     temp_reg;
    logic [WW-1:0]                     diff_reg;
    logic [PW-1:0]                     wp_reg;
    logic [PW-1:0]                     pos_reg;
    logic [NW-1:0]                     fill_count_reg;
    logic [WW-1:0]                     sum_reg;
    logic [WW-1:0]                     rd_data_reg;
    logic [WW-1:0]                     quo_reg;
    logic [NW-1:0]                     rem_reg;
    logic                              neg_reg;
    logic                              valid_reg;
    logic [tgt_pkg::DIV_CNT_W-1:0]     cnt_reg;

    logic [WW-1:0]                     ring [MAX_WINDOW];

    logic                              s_accept;
    logic                              cfg_write;
    logic [NW-1:0]                     eff_window;
    logic [PW-1:0]                     pos_next;
    logic [WW-1:0]                     temp_next;
    logic                              ring_full;
    logic [WW-1:0]                     sum_base;
    logic [WW-1:0]                     sum_next;
    logic [NW-1:0]                     fill_next;
    logic [CW-1:0]                     pos_inc;
    logic [PW-1:0]                     wp_next;
    logic [WW-1:0]                     sum_abs;
    logic [NW:0]                       rem_shift;
    logic [NW:0]                       rem_sub;
    logic                              rem_ge;
    logic [NW-1:0]                     rem_next;
    logic [WW-1:0]                     gradient_next;
    logic                              out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        if (window_len_reg == '0) begin
            eff_window = NW'(1);
        end else if (32'(window_len_reg) > MAX_WINDOW) begin
            eff_window = NW'(MAX_WINDOW);
        end else begin
            eff_window = window_len_reg;
        end
    end

    // Wrap the write position if the window shrank below it
    assign pos_next  = (CW'(wp_reg) >= CW'(eff_window)) ? '0 : wp_reg;
    assign temp_next = tgt_pkg::temp_from_sample(sample_reg);

    assign ring_full = fill_count_reg >= eff_window;
    assign sum_base  = ring_full ? (sum_reg - rd_data_reg) : sum_reg;
    assign sum_next  = sum_base + diff_reg;
    assign fill_next = ring_full ? fill_count_reg : (fill_count_reg + NW'(1));
    assign pos_inc   = CW'(pos_reg) + CW'(1);
    assign wp_next   = (pos_inc >= CW'(eff_window)) ? '0 : pos_inc[PW-1:0];
    assign sum_abs   = sum_next[WW-1] ? (-sum_next) : sum_next;

    // One restoring division step per cycle
    assign rem_shift = {rem_reg, quo_reg[WW-1]};
    assign rem_ge    = rem_shift >= {1'b0, eff_window};
    assign rem_sub   = rem_shift - {1'b0, eff_window};
    assign rem_next  = rem_ge ? rem_sub[NW-1:0] : rem_shift[NW-1:0];

    assign gradient_next = neg_reg ? (-quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= ring[pos_next];
        end
        if (state_reg == S_SUM && use_ring_reg) begin
            ring[pos_reg] <= diff_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            window_len_reg <= tgt_pkg::WINDOW_RESET;
            prev_temp_reg  <= '0;
            have_prev_reg  <= 1'b0;
            wp_reg         <= '0;
            fill_count_reg <= '0;
            sum_reg        <= '0;
        end else begin
            // Drop the result once taken, unless a new one loads in its place
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_write && paddr[2] == tgt_pkg::REG_WINDOW_LEN) begin
                window_len_reg <= pwdata[NW-1:0];
                wp_reg         <= '0;
                fill_count_reg <= '0;
                sum_reg        <= '0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        sample_reg <= s_tdata[tgt_pkg::SAMPLE_W-1:0];
                        pos_reg    <= pos_next;
                        state_reg  <= S_CALC;
                    end
                end
                S_CALC: begin
                    temp_reg      <= temp_next;
                    diff_reg      <= temp_next - prev_temp_reg;
                    prev_temp_reg <= temp_next;
                    use_ring_reg  <= have_prev_reg;
                    have_prev_reg <= 1'b1;
                    state_reg     <= S_SUM;
                end
                S_SUM: begin
                    if (use_ring_reg) begin
                        sum_reg        <= sum_next;
                        fill_count_reg <= fill_next;
                        wp_reg         <= wp_next;
                    end
                    if (use_ring_reg && fill_next >= eff_window) begin
                        quo_reg   <= sum_abs;
                        neg_reg   <= sum_next[WW-1];
                        rem_reg   <= '0;
                        cnt_reg   <= tgt_pkg::DIV_CNT_W'(WW);
                        valid_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end else begin
                        quo_reg   <= '0;
                        neg_reg   <= 1'b0;
                        valid_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[WW-2:0], rem_ge};
                    cnt_reg <= cnt_reg - tgt_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == tgt_pkg::DIV_CNT_W'(1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, gradient_next, temp_reg};
                        m_tuser_reg  <= valid_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign prdata   = tgt_pkg::DATA_W'(window_len_reg);
    assign pready   = 1'b1;

    `TGT_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_count_reg <= eff_window, "fill high")
    `TGT_ASSERT_NOW(a_wp_bound, aclk, aresetn, 1'b1, CW'(wp_reg) < CW'(eff_window), "wp high")
    `TGT_ASSERT_NOW(a_grad_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[37:19] == '0, "grad")
    `TGT_ASSERT_NEXT(a_accept_calc, aclk, aresetn, s_accept, state_reg == S_CALC, "no convert")

endmodule

[tb/temperature_gradient_tracker_tb.sv]
// ----------------------------------------------------------------------------
// temperature_gradient_tracker_tb
// Self-checking testbench for the temperature gradient tracker.
// ----------------------------------------------------------------------------
// Sends ADC samples over the input stream and rebuilds every result in a
// local model: temperature conversion, difference ring, running sum and the
// truncated mean. Starts with corner samples, then runs random phases under
// several window lengths, including 0 and out-of-range values. Both stream
// sides stall at random. One phase has no stalls. One phase holds the
// receiver off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module temperature_gradient_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEMP_GAIN    = 225;
    localparam int TEMP_BIAS    = 14848;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 27;

    localparam logic [tgt_pkg::ADDR_W-1:0] WINDOW_ADDR = 3'd0;
    localparam logic [tgt_pkg::ADDR_W-1:0] SPARE_ADDR  = 3'd4;

    typedef struct {
        logic [tgt_pkg::WORD_W-1:0] temp;
        logic [tgt_pkg::WORD_W-1:0] grad;
        logic                       valid;
    } reading_t;

    class gradient_scoreboard;
        int unsigned window_reg;
        int          prev_temp;
        bit          have_prev;
        int          diffs[tgt_pkg::DEF_MAX_WIN];
        int          wr_pos;
        int          fill;
        int          sum;
        int          errors;
        reading_t    readings_q[$];

        function new();
            window_reg = tgt_pkg::WINDOW_RESET;
            prev_temp  = 0;
            have_prev  = 0;
            errors     = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            wr_pos = 0;
            fill   = 0;
            sum    = 0;
        endfunction

        function int wrap_word(int v);
            int u;
            u = v & 'h7FFFF;
            if (u >= 'h40000) u -= 'h80000;
            return u;
        endfunction

        function void set_window(logic [tgt_pkg::WIN_W-1:0] value);
            window_reg = value;
            clear_ring();
        endfunction

        // Compute the reading the block must return for one accepted sample.
        function void note_sample(logic [tgt_pkg::SAMPLE_W-1:0] smp);
            int       t;
            int       n;
            int       pos;
            int       d;
            int       q;
            reading_t r;
            t = int'(smp) * TEMP_GAIN - TEMP_BIAS;
            q = 0;
            r.valid = 1'b0;
            if (have_prev) begin
                n = (window_reg == 0) ? 1 :
                    (window_reg > tgt_pkg::DEF_MAX_WIN) ? tgt_pkg::DEF_MAX_WIN : window_reg;
                pos = (wr_pos >= n) ? 0 : wr_pos;
                d = t - prev_temp;
                if (fill >= n) sum = wrap_word(sum - diffs[pos]);
                else fill++;
                diffs[pos] = d;
                sum = wrap_word(sum + d);
                pos++;
                wr_pos = (pos >= n) ? 0 : pos;
                if (fill >= n) begin
                    q = sum / n;
                    r.valid = 1'b1;
                end
            end
            prev_temp = t;
            have_prev = 1;
            r.temp = t[tgt_pkg::WORD_W-1:0];
            r.grad = q[tgt_pkg::WORD_W-1:0];
            readings_q.push_back(r);
        endfunction

        function void check_result(logic [tgt_pkg::M_TDATA_W-1:0] data, logic flag);
            reading_t e;
            logic [tgt_pkg::WORD_W-1:0] got_temp;
            logic [tgt_pkg::WORD_W-1:0] got_grad;
            if (readings_q.size() == 0) begin
                $error("result transaction with no reading pending");
                errors++;
                return;
            end
            e = readings_q.pop_front();
            got_temp = data[tgt_pkg::WORD_W-1:0];
            got_grad = data[2*tgt_pkg::WORD_W-1:tgt_pkg::WORD_W];
            if (got_temp !== e.temp) begin
                $error("temperature_q8: expected %0d, got %0d", $signed(e.temp),
                       $signed(got_temp));
                errors++;
            end
            if (got_grad !== e.grad) begin
                $error("gradient_q8: expected %0d, got %0d", $signed(e.grad),
                       $signed(got_grad));
                errors++;
            end
            if (flag !== e.valid) begin
                $error("gradient_valid: expected %0b, got %0b", e.valid, flag);
                errors++;
            end
        endfunction

        function int outstanding();
            return readings_q.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tgt_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tgt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tgt_pkg::ADDR_W-1:0]     paddr;
    logic [tgt_pkg::DATA_W-1:0]     pwdata;
    logic [tgt_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    gradient_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    int rx_hold;
    int last_sample;
    int cycles;

    int corner_samples[14] = '{0, 1023, 1023, 0, 0, 1023, 66, 65, 512, 1, 1022, 513, 1023, 0};
    int phase_windows[10]  = '{2, 64, 1, 127, 3, 0, 8, 65, 17, 40};

    temperature_gradient_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = !(rx_idle && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    function logic [tgt_pkg::SAMPLE_W-1:0] next_sample();
        int mode;
        int v;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            v = $urandom_range(0, 1023);
        end else if (mode < 8) begin
            // slow drift, like a real sensor
            v = last_sample + int'($urandom_range(0, 20)) - 10;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
        end else begin
            v = $urandom_range(0, 1) ? 1023 : 0;
        end
        last_sample = v;
        return v[tgt_pkg::SAMPLE_W-1:0];
    endfunction

    // Enter and leave at a falling edge; tvalid stays high for the next item.
    task automatic send_sample(input logic [tgt_pkg::SAMPLE_W-1:0] smp);
        while (tx_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(tgt_pkg::S_TDATA_W - tgt_pkg::SAMPLE_W){1'b0}}, smp};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [tgt_pkg::ADDR_W-1:0] addr,
                             input logic [tgt_pkg::WIN_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = ($urandom() & ~32'h7F) | 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == WINDOW_ADDR) sb.set_window(value);
    endtask

    task automatic window_readback(input logic [tgt_pkg::WIN_W-1:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = WINDOW_ADDR;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[tgt_pkg::WIN_W-1:0] !== want) begin
            $error("window_len: expected %0d, got %0d", want, prdata[tgt_pkg::WIN_W-1:0]);
            sb.errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        int w;
        int eff;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        rx_hold     = 0;
        last_sample = 512;
        phase_windows[9] = $urandom_range(4, 60);
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset window of 8: first sample, full swings, temperatures near zero.
        window_readback(tgt_pkg::WINDOW_RESET);
        foreach (corner_samples[i]) send_sample(corner_samples[i][tgt_pkg::SAMPLE_W-1:0]);
        wait_drained();

        // Zero window acts as one: largest positive and negative gradients.
        cfg_write(WINDOW_ADDR, 7'd0);
        window_readback(7'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
        wait_drained();

        // Write to an unmapped register must leave the window intact.
        cfg_write(SPARE_ADDR, 7'd5);
        window_readback(7'd0);
        send_sample(10'd0);
        send_sample(10'd700);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            w = phase_windows[p];
            eff = (w == 0) ? 1 : (w > tgt_pkg::DEF_MAX_WIN) ? tgt_pkg::DEF_MAX_WIN : w;
            cfg_write(WINDOW_ADDR, w[tgt_pkg::WIN_W-1:0]);
            window_readback(w[tgt_pkg::WIN_W-1:0]);
            tx_idle = (p != 1);
            rx_idle = (p != 1);
            if (p == 6) begin
                // back the block up: sender keeps offering while results pile up
                tx_idle = 1'b0;
                rx_hold = HOLD_CYCLES;
            end
            repeat (eff + 20) send_sample(next_sample());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
